>>> design/sigma_point_generator_unit_defines.svh
// assertion macros for the sigma point generator
`ifndef SIGMA_POINT_GENERATOR_UNIT_DEFINES_SVH
`define SIGMA_POINT_GENERATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SPG_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SPG_ASSERT(lbl, prop, msg)
`define SPG_ASSERT_NR(lbl, prop, msg)
`endif
`endif

>>> design/spg_pkg.sv
// shared types and constants of the sigma point generator
package spg_pkg;

  localparam int IDX_W  = 3;
  localparam int VAL_W  = 32;
  localparam int WGT_W  = 48;
  localparam int DIV_W  = 64;
  localparam int ROOT_W = 32;

  localparam logic [1:0] CFG_DIM   = 2'd0;
  localparam logic [1:0] CFG_ALPHA = 2'd1;
  localparam logic [1:0] CFG_BETA  = 2'd2;
  localparam logic [1:0] CFG_KAPPA = 2'd3;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_NOT_PD = 2'd1;
  localparam logic [1:0] FAULT_SPREAD = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_A2,
    OP_SPROD,
    OP_S,
    OP_CRD,
    OP_CLOAD,
    OP_MUL,
    OP_ACC,
    OP_SQRT_ACC,
    OP_WR_ROOT,
    OP_DIV_L,
    OP_WR_L,
    OP_SQRT_G,
    OP_GAMMA,
    OP_DIV_W0,
    OP_W0,
    OP_DIV_WI,
    OP_WI,
    OP_ERD,
    OP_EMUL,
    OP_EOUT,
    OP_FAULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic [1:0]       fault;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic             s_nonpos;
    logic             acc_nonpos;
    logic             sqrt_done;
    logic             div_done;
    logic             out_free;
    logic [IDX_W-1:0] n;
  } dp_stat_t;

endpackage

>>> design/spg_divider.sv
// iterative restoring divider, one quotient bit per cycle
module spg_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [spg_pkg::DIV_W-1:0] num_i,
  input  logic [spg_pkg::DIV_W-1:0] den_i,
  output logic                     done_o,
  output logic [spg_pkg::DIV_W-1:0] quo_o
);
  import spg_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DIV_W-1:0] num_q, den_q, rem_q, rem_d;
  logic [DIV_W:0]   rem_sh;
  logic             qbit;

  always_comb begin
    rem_sh = {rem_q, num_q[DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    rem_d  = qbit ? DIV_W'(rem_sh - {1'b0, den_q}) : DIV_W'(rem_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[DIV_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
endmodule

>>> design/spg_sqrt.sv
// iterative integer square root, two radicand bits per cycle
module spg_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [spg_pkg::DIV_W-1:0]  rad_i,
  output logic                      done_o,
  output logic [spg_pkg::ROOT_W-1:0] root_o
);
  import spg_pkg::*;

  localparam int CW = $clog2(ROOT_W);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DIV_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ROOT_W+1:0] rem_q, rem_d;
  logic [ROOT_W+3:0] rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q, rad_q[DIV_W-1:DIV_W-2]};
    trial  = {2'b00, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = (ROOT_W+2)'(rem_sh - trial);
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = (ROOT_W+2)'(rem_sh);
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ROOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[DIV_W-3:0], 2'b00};
      root_q <= root_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

>>> design/spg_datapath.sv
// datapath: stores, configuration, arithmetic and the result register
module spg_datapath #(
  parameter int DIM_MAX = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [31:0]               cfg_data_i,
  input  logic                      in_we_i,
  input  logic                      func_i,
  input  logic [spg_pkg::IDX_W-1:0] row_index_i,
  input  logic [spg_pkg::IDX_W-1:0] col_index_i,
  input  logic signed [31:0]        element_value_i,
  input  spg_pkg::dp_cmd_t          cmd_i,
  output spg_pkg::dp_stat_t         stat_o,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [spg_pkg::IDX_W-1:0] point_column_o,
  output logic [spg_pkg::IDX_W-1:0] element_row_o,
  output logic signed [31:0]        plus_value_o,
  output logic signed [31:0]        minus_value_o,
  output logic signed [47:0]        mean_weight_o,
  output logic signed [47:0]        cov_weight_o,
  output logic [1:0]                fault_code_o,
  output logic                      last_result_o
);
  import spg_pkg::*;

  localparam int DEPTH = DIM_MAX * DIM_MAX;
  localparam int RW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] DM = AW'(DIM_MAX);
  localparam logic [IDX_W-1:0] DMAX = IDX_W'(DIM_MAX);
  localparam logic signed [64:0] QMAX = 65'sd1 <<< 62;

  function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -(((-v) + half) >>> sh);
  endfunction

  function automatic logic signed [31:0] sat32(input logic [63:0] q, input logic neg);
    if (!neg) return (q > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(q);
    return (q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - q);
  endfunction

  function automatic logic signed [47:0] sat48(input logic [63:0] q, input logic neg);
    if (!neg) return (q > 64'h7fff_ffff_ffff) ? 48'sh7fff_ffff_ffff : 48'(q);
    return (q > 64'h8000_0000_0000) ? 48'sh8000_0000_0000 : 48'(64'd0 - q);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [43:0] v);
    if (v > 44'sh000_7fff_ffff) return 32'sh7fff_ffff;
    if (v < -44'sh000_8000_0000) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  // configuration
  logic [2:0]         dim_q;
  logic [25:0]        alpha_q;
  logic [23:0]        beta_q;
  logic signed [31:0] kappa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= 3'd4;
      alpha_q <= 26'd16777216;
      beta_q  <= 24'd131072;
      kappa_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIM:   dim_q   <= cfg_data_i[2:0];
        CFG_ALPHA: alpha_q <= cfg_data_i[25:0];
        CFG_BETA:  beta_q  <= cfg_data_i[23:0];
        CFG_KAPPA: kappa_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [IDX_W-1:0] n_eff;
  assign n_eff = (dim_q == '0) ? IDX_W'(1) : ((dim_q > DMAX) ? DMAX : dim_q);

  // stores
  logic signed [31:0] mean_q [DIM_MAX];
  logic signed [31:0] cov_mem [DEPTH];
  logic signed [31:0] fac_mem [DEPTH];
  logic signed [31:0] cov_rd_q, fa_q, fb_q;
  logic [AW-1:0] in_addr, ij_addr, a_addr, b_addr;
  logic [IDX_W-1:0] kcol, cm1;
  logic fac_we;
  logic signed [31:0] fac_wdata;

  assign in_addr = AW'(row_index_i) * DM + AW'(col_index_i);
  assign ij_addr = AW'(cmd_i.i) * DM + AW'(cmd_i.j);
  assign cm1     = (cmd_i.j == '0) ? '0 : cmd_i.j - 1'b1;
  assign kcol    = (cmd_i.op == OP_ERD) ? cm1 : cmd_i.k;
  assign a_addr  = AW'(cmd_i.i) * DM + AW'(kcol);
  assign b_addr  = AW'(cmd_i.j) * DM + AW'(cmd_i.k);

  always_ff @(posedge clk_i) begin
    if (in_we_i && row_index_i < DMAX) begin
      if (!func_i) mean_q[row_index_i[RW-1:0]] <= element_value_i;
      else if (col_index_i < DMAX) cov_mem[in_addr] <= element_value_i;
    end
    cov_rd_q <= cov_mem[ij_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fac_we) fac_mem[ij_addr] <= fac_wdata;
    fa_q <= fac_mem[a_addr];
    fb_q <= fac_mem[b_addr];
  end

  // arithmetic registers
  logic [51:0]        a2_q;
  logic signed [62:0] sprod_q;
  logic signed [35:0] s_q;
  logic signed [63:0] acc_q, prod_q;
  logic [30:0]        piv_q;
  logic [25:0]        gamma_q;
  logic signed [47:0] w0m_q, w0c_q, wi_q;
  logic signed [58:0] eprod_q;
  logic               neg_q;

  logic [27:0]        a2q_w;
  logic [19:0]        a2r_w;
  logic signed [33:0] base_w;
  logic signed [36:0] lambda_w;
  logic [36:0]        lam_mag;
  logic signed [64:0] diff_w, acc_clamped;
  logic [63:0]        acc_mag;
  logic [30:0]        root_sat;
  logic signed [49:0] w0c_sum;
  logic signed [47:0] w0c_w;
  logic signed [63:0] sh_w;
  logic signed [43:0] sh_n, m_w;

  logic sqrt_start, sqrt_done, div_start, div_done;
  logic [DIV_W-1:0]  sqrt_in, div_num, div_den, quo;
  logic [ROOT_W-1:0] root;

  always_comb begin
    a2q_w    = 28'((a2_q + 52'd8388608) >> 24);
    a2r_w    = 20'((a2_q + 52'h0_0000_8000_0000) >> 32);
    base_w   = $signed({15'd0, n_eff, 16'd0}) + 34'(kappa_q);
    lambda_w = 37'(s_q) - $signed({18'd0, n_eff, 16'd0});
    lam_mag  = lambda_w[36] ? 37'(-lambda_w) : 37'(lambda_w);
    diff_w   = 65'(acc_q) - 65'(prod_q);
    if (diff_w > QMAX) acc_clamped = QMAX;
    else if (diff_w < -QMAX) acc_clamped = -QMAX;
    else acc_clamped = diff_w;
    acc_mag  = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
    root_sat = root[31] ? 31'h7fff_ffff : root[30:0];
    w0c_sum  = 50'(w0m_q) + 50'sd65536 - $signed({30'd0, a2r_w})
             + $signed({26'd0, beta_q});
    if (w0c_sum > 50'sh0_7fff_ffff_ffff) w0c_w = 48'sh7fff_ffff_ffff;
    else if (w0c_sum < -50'sh0_8000_0000_0000) w0c_w = 48'sh8000_0000_0000;
    else w0c_w = 48'(w0c_sum);
    sh_w     = rsh(64'(eprod_q), 16);
    sh_n     = 44'(sh_w);
    m_w      = 44'(mean_q[cmd_i.i[RW-1:0]]);
  end

  always_comb begin
    sqrt_start = (cmd_i.op == OP_SQRT_ACC) || (cmd_i.op == OP_SQRT_G);
    sqrt_in    = (cmd_i.op == OP_SQRT_ACC) ? 64'(acc_q) : (64'(s_q) << 16);
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    case (cmd_i.op)
      OP_DIV_L: begin
        div_start = 1'b1;
        div_num   = acc_mag + 64'(piv_q >> 1);
        div_den   = 64'(piv_q);
      end
      OP_DIV_W0: begin
        div_start = 1'b1;
        div_num   = 64'({lam_mag, 16'd0}) + 64'(s_q >>> 1);
        div_den   = 64'(s_q);
      end
      OP_DIV_WI: begin
        div_start = 1'b1;
        div_num   = 64'h1_0000_0000 + 64'(s_q);
        div_den   = 64'(s_q) << 1;
      end
      default: ;
    endcase
    fac_we    = (cmd_i.op == OP_WR_ROOT) || (cmd_i.op == OP_WR_L);
    fac_wdata = (cmd_i.op == OP_WR_ROOT) ? $signed({1'b0, root_sat}) : sat32(quo, neg_q);
  end

  spg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_in),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  spg_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_A2:      a2_q    <= alpha_q * alpha_q;
      OP_SPROD:   sprod_q <= $signed({1'b0, a2q_w}) * base_w;
      OP_S:       s_q     <= 36'(rsh(64'(sprod_q), 24));
      OP_CLOAD:   acc_q   <= {{16{cov_rd_q[31]}}, cov_rd_q, 16'd0};
      OP_MUL:     prod_q  <= fa_q * fb_q;
      OP_ACC:     acc_q   <= 64'(acc_clamped);
      OP_WR_ROOT: piv_q   <= root_sat;
      OP_GAMMA:   gamma_q <= root[25:0];
      OP_W0:      w0m_q   <= sat48(quo, neg_q);
      OP_WI: begin
        wi_q  <= 48'(quo);
        w0c_q <= w0c_w;
      end
      OP_EMUL: begin
        // column zero and the upper triangle carry no shift
        if (cmd_i.j == '0 || cmd_i.i < cm1) eprod_q <= '0;
        else eprod_q <= fa_q * $signed({1'b0, gamma_q});
      end
      default: ;
    endcase
    if (cmd_i.op == OP_DIV_L) neg_q <= acc_q[63];
    else if (cmd_i.op == OP_DIV_W0) neg_q <= lambda_w[36];
  end

  // result register
  logic out_valid_q;
  logic out_load;
  assign out_load = (cmd_i.op == OP_EOUT) || (cmd_i.op == OP_FAULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EOUT) begin
      point_column_o <= cmd_i.j;
      element_row_o  <= cmd_i.i;
      plus_value_o   <= clip32(m_w + sh_n);
      minus_value_o  <= clip32(m_w - sh_n);
      mean_weight_o  <= (cmd_i.j == '0) ? w0m_q : wi_q;
      cov_weight_o   <= (cmd_i.j == '0) ? w0c_q : wi_q;
      fault_code_o   <= FAULT_NONE;
      last_result_o  <= cmd_i.last;
    end else if (cmd_i.op == OP_FAULT) begin
      point_column_o <= '0;
      element_row_o  <= '0;
      plus_value_o   <= '0;
      minus_value_o  <= '0;
      mean_weight_o  <= '0;
      cov_weight_o   <= '0;
      fault_code_o   <= cmd_i.fault;
      last_result_o  <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign stat_o.s_nonpos   = s_q[35] || (s_q == '0);
  assign stat_o.acc_nonpos = acc_q[63] || (acc_q == '0);
  assign stat_o.sqrt_done  = sqrt_done;
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;
  assign stat_o.n          = n_eff;
endmodule

>>> design/spg_ctrl.sv
// run sequencer: spread, factorization, weights and result emission
module spg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  spg_pkg::dp_stat_t stat_i,
  output spg_pkg::dp_cmd_t  cmd_o,
  output logic              idle_o
);
  import spg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_A2, ST_SPROD, ST_S, ST_SCHK, ST_CRD, ST_CLOAD, ST_MUL, ST_ACC,
    ST_PIV, ST_SQRT, ST_DIV, ST_GSQ, ST_GWAIT, ST_W0, ST_W0WAIT, ST_WI,
    ST_WIWAIT, ST_ERD, ST_EMUL, ST_EOUT, ST_FAULT
  } state_e;

  state_e state_q;
  logic [IDX_W-1:0] i_q, j_q, k_q, k_nx, nm1;
  logic [1:0] fault_q;
  logic last_w;

  assign k_nx   = k_q + 1'b1;
  assign nm1    = stat_i.n - 1'b1;
  assign last_w = (j_q == stat_i.n) && (i_q == nm1);

  always_comb begin
    cmd_o.op    = OP_NONE;
    cmd_o.i     = i_q;
    cmd_o.j     = j_q;
    cmd_o.k     = k_q;
    cmd_o.fault = fault_q;
    cmd_o.last  = last_w;
    unique case (state_q)
      ST_A2:    cmd_o.op = OP_A2;
      ST_SPROD: cmd_o.op = OP_SPROD;
      ST_S:     cmd_o.op = OP_S;
      ST_CRD:   cmd_o.op = OP_CRD;
      ST_CLOAD: begin
        cmd_o.op = OP_CLOAD;
        cmd_o.k  = '0;
      end
      ST_MUL:   cmd_o.op = OP_MUL;
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        cmd_o.k  = k_nx;
      end
      ST_PIV: begin
        if (i_q != j_q) cmd_o.op = OP_DIV_L;
        else if (!stat_i.acc_nonpos) cmd_o.op = OP_SQRT_ACC;
      end
      ST_SQRT:   if (stat_i.sqrt_done) cmd_o.op = OP_WR_ROOT;
      ST_DIV:    if (stat_i.div_done) cmd_o.op = OP_WR_L;
      ST_GSQ:    cmd_o.op = OP_SQRT_G;
      ST_GWAIT:  if (stat_i.sqrt_done) cmd_o.op = OP_GAMMA;
      ST_W0:     cmd_o.op = OP_DIV_W0;
      ST_W0WAIT: if (stat_i.div_done) cmd_o.op = OP_W0;
      ST_WI:     cmd_o.op = OP_DIV_WI;
      ST_WIWAIT: if (stat_i.div_done) cmd_o.op = OP_WI;
      ST_ERD:    cmd_o.op = OP_ERD;
      ST_EMUL:   cmd_o.op = OP_EMUL;
      ST_EOUT:   if (stat_i.out_free) cmd_o.op = OP_EOUT;
      ST_FAULT:  if (stat_i.out_free) cmd_o.op = OP_FAULT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      fault_q <= FAULT_NONE;
    end else begin
      unique case (state_q)
        ST_IDLE:  if (start_i) state_q <= ST_A2;
        ST_A2:    state_q <= ST_SPROD;
        ST_SPROD: state_q <= ST_S;
        ST_S:     state_q <= ST_SCHK;
        ST_SCHK: begin
          i_q <= '0;
          j_q <= '0;
          if (stat_i.s_nonpos) begin
            fault_q <= FAULT_SPREAD;
            state_q <= ST_FAULT;
          end else begin
            state_q <= ST_CRD;
          end
        end
        ST_CRD: state_q <= ST_CLOAD;
        ST_CLOAD: begin
          k_q     <= '0;
          state_q <= (j_q == '0) ? ST_PIV : ST_MUL;
        end
        ST_MUL: state_q <= ST_ACC;
        ST_ACC: begin
          k_q     <= k_nx;
          state_q <= (k_nx < j_q) ? ST_MUL : ST_PIV;
        end
        ST_PIV: begin
          if (i_q != j_q) state_q <= ST_DIV;
          else if (stat_i.acc_nonpos) begin
            fault_q <= FAULT_NOT_PD;
            state_q <= ST_FAULT;
          end else state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          if (stat_i.sqrt_done) begin
            if (j_q == nm1) state_q <= ST_GSQ;
            else begin
              i_q     <= j_q + 1'b1;
              state_q <= ST_CRD;
            end
          end
        end
        ST_DIV: begin
          if (stat_i.div_done) begin
            // next row of this column; after its last row, continue with the next diagonal
            if (i_q != nm1) i_q <= i_q + 1'b1;
            else begin
              i_q <= j_q + 1'b1;
              j_q <= j_q + 1'b1;
            end
            state_q <= ST_CRD;
          end
        end
        ST_GSQ:    state_q <= ST_GWAIT;
        ST_GWAIT:  if (stat_i.sqrt_done) state_q <= ST_W0;
        ST_W0:     state_q <= ST_W0WAIT;
        ST_W0WAIT: if (stat_i.div_done) state_q <= ST_WI;
        ST_WI:     state_q <= ST_WIWAIT;
        ST_WIWAIT: begin
          if (stat_i.div_done) begin
            i_q     <= '0;
            j_q     <= '0;
            fault_q <= FAULT_NONE;
            state_q <= ST_ERD;
          end
        end
        ST_ERD:  state_q <= ST_EMUL;
        ST_EMUL: state_q <= ST_EOUT;
        ST_EOUT: begin
          if (stat_i.out_free) begin
            if (last_w) state_q <= ST_IDLE;
            else begin
              if (i_q != nm1) i_q <= i_q + 1'b1;
              else begin
                i_q <= '0;
                j_q <= j_q + 1'b1;
              end
              state_q <= ST_ERD;
            end
          end
        end
        ST_FAULT: if (stat_i.out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign idle_o = (state_q == ST_IDLE);
endmodule

>>> design/sigma_point_generator_unit.sv
// top level of the unscented transform sigma point generator
`include "sigma_point_generator_unit_defines.svh"
// Load items (mean and covariance elements) transfer one per cycle while the
// block is idle; the item with load_done starts a run and the input stalls
// until the run's last result is in the output register. A run computes the
// spread, then for each lower-triangle element (i,j) a multiply-accumulate
// plus the shared square-root unit on the diagonal or the shared divider off
// it, then gamma and the weights, then emits n*(n+1) results. The two serial
// units and the single multiply per step set the run time. A faulty run gives
// one result.
module sigma_point_generator_unit #(
  parameter int DIM_MAX = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [31:0]               cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      func_i,
  input  logic [spg_pkg::IDX_W-1:0] row_index_i,
  input  logic [spg_pkg::IDX_W-1:0] col_index_i,
  input  logic signed [31:0]        element_value_i,
  input  logic                      load_done_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [spg_pkg::IDX_W-1:0] point_column_o,
  output logic [spg_pkg::IDX_W-1:0] element_row_o,
  output logic signed [31:0]        plus_value_o,
  output logic signed [31:0]        minus_value_o,
  output logic signed [47:0]        mean_weight_o,
  output logic signed [47:0]        cov_weight_o,
  output logic [1:0]                fault_code_o,
  output logic                      last_result_o
);
  import spg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic idle, in_xfer;

  assign in_stall_o = !idle;
  assign in_xfer    = in_valid_i && idle;

  spg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer && load_done_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .idle_o  (idle)
  );

  spg_datapath #(.DIM_MAX(DIM_MAX)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_we_i         (in_xfer),
    .func_i          (func_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .point_column_o  (point_column_o),
    .element_row_o   (element_row_o),
    .plus_value_o    (plus_value_o),
    .minus_value_o   (minus_value_o),
    .mean_weight_o   (mean_weight_o),
    .cov_weight_o    (cov_weight_o),
    .fault_code_o    (fault_code_o),
    .last_result_o   (last_result_o)
  );

  `SPG_ASSERT(a_fault_is_last, out_valid_o && fault_code_o != FAULT_NONE |-> last_result_o, "fault result not marked last")
  `SPG_ASSERT(a_fault_zero, out_valid_o && fault_code_o != FAULT_NONE |-> plus_value_o == 0 && mean_weight_o == 0, "fault result carries data")
  `SPG_ASSERT_NR(a_fault_code, out_valid_o |-> fault_code_o == FAULT_NONE || fault_code_o == FAULT_NOT_PD || fault_code_o == FAULT_SPREAD, "bad fault code")
  `SPG_ASSERT(a_out_ranges, out_valid_o |-> element_row_o < DIM_MAX && point_column_o <= DIM_MAX, "result index out of range")
endmodule

>>> tb/tb_sigma_point_generator_unit.sv
// self-checking testbench of the sigma point generator top level
module tb_sigma_point_generator_unit;
  import spg_pkg::*;

  localparam int      DIM_MAX     = 7;
  localparam int      ITEM_TARGET = 350;
  localparam int      CYCLE_LIMIT = 1000000;
  localparam int      SETTLE      = 64;
  localparam logic    FUNC_MEAN   = 1'b0;
  localparam logic    FUNC_COV    = 1'b1;
  localparam longint  Q62         = 64'sh4000000000000000;
  localparam longint  W48_HI      = 64'sh00007FFFFFFFFFFF;
  localparam longint  W48_LO      = -64'sh0000800000000000;

  typedef struct {
    logic        func;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        done;
  } load_item_t;

  typedef struct {
    logic [2:0]         col;
    logic [2:0]         row;
    logic signed [31:0] plus;
    logic signed [47:0] wm;
    logic signed [31:0] minus;
    logic signed [47:0] wc;
    logic [1:0]         fault;
    logic               last;
  } sigma_elem_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func_d = 1'b0;
  logic [2:0] row_d = '0;
  logic [2:0] col_d = '0;
  logic signed [31:0] value_d = '0;
  logic done_d = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] point_column, element_row;
  logic signed [31:0] plus_value, minus_value;
  logic signed [47:0] mean_weight, cov_weight;
  logic [1:0] fault_code;
  logic last_result;

  always #2 clk_i = ~clk_i;

  sigma_point_generator_unit #(.DIM_MAX(DIM_MAX)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func_d), .row_index_i(row_d), .col_index_i(col_d),
    .element_value_i(value_d), .load_done_i(done_d),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .point_column_o(point_column), .element_row_o(element_row),
    .plus_value_o(plus_value), .minus_value_o(minus_value),
    .mean_weight_o(mean_weight), .cov_weight_o(cov_weight),
    .fault_code_o(fault_code), .last_result_o(last_result)
  );

  // predictor state
  logic [2:0]         dim_reg = 3'd4;
  logic [25:0]        alpha_reg = 26'd16777216;
  logic [23:0]        beta_reg = 24'd131072;
  logic signed [31:0] kappa_reg = '0;
  longint mean_mem [DIM_MAX];
  longint cov_mem [DIM_MAX*DIM_MAX];
  longint chol_mem [DIM_MAX*DIM_MAX];

  load_item_t  pending_q[$];
  sigma_elem_t points_q[$];
  load_item_t  cur;
  int  gap_left = 0;
  int  stall_left = 0;
  int  stall_next_cnt;
  logic stall_nxt;
  bit  quiet = 0;
  int  errors = 0;
  int  cycles = 0;
  int  items_sent = 0;

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat32(longint v);
    return clampv(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint rnd_shift(longint v, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -(((-v) + half) >>> sh);
  endfunction

  function automatic longint div_round(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -(((-num) + den / 2) / den);
  endfunction

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic sigma_elem_t mk_elem(int c, int r, longint p, longint m, longint wm,
                                          longint wc, logic [1:0] f, logic l);
    sigma_elem_t e;
    e.col = c[2:0];
    e.row = r[2:0];
    e.plus = p[31:0];
    e.minus = m[31:0];
    e.wm = wm[47:0];
    e.wc = wc[47:0];
    e.fault = f;
    e.last = l;
    return e;
  endfunction

  // store one accepted load item and, on load_done, queue the sigma points or the fault result
  task automatic predict_points(load_item_t it);
    int n, i, j, k, c, r;
    longint unsigned a2, root;
    longint a2q, s, lam, gam, w0m, w0c, wi, acc, m, sh, l;
    bit bad;
    bad = 0;
    if (it.row < DIM_MAX) begin
      if (it.func == FUNC_MEAN) mean_mem[it.row] = longint'(signed'(it.value));
      else if (it.col < DIM_MAX) cov_mem[it.row*DIM_MAX + it.col] = longint'(signed'(it.value));
    end
    if (!it.done) return;
    n = (dim_reg == 0) ? 1 : int'(dim_reg);
    a2 = longint'(alpha_reg) * longint'(alpha_reg);
    a2q = longint'((a2 + (64'h1 << 23)) >> 24);
    s = rnd_shift(a2q * (longint'(n) * 65536 + longint'(kappa_reg)), 24);
    if (s <= 0) begin
      points_q.push_back(mk_elem(0, 0, 0, 0, 0, 0, FAULT_SPREAD, 1'b1));
      return;
    end
    lam = s - longint'(n) * 65536;
    for (j = 0; j < n && !bad; j++) begin
      acc = cov_mem[j*DIM_MAX + j] * 65536;
      for (k = 0; k < j; k++) begin
        l = chol_mem[j*DIM_MAX + k];
        acc = clampv(acc - l * l, -Q62, Q62);
      end
      if (acc <= 0) begin
        bad = 1;
      end else begin
        root = isqrt64(longint'(acc));
        if (root > 64'd2147483647) root = 64'd2147483647;
        chol_mem[j*DIM_MAX + j] = longint'(root);
        for (i = 0; i < j; i++) chol_mem[i*DIM_MAX + j] = 0;
        for (i = j + 1; i < n; i++) begin
          acc = cov_mem[i*DIM_MAX + j] * 65536;
          for (k = 0; k < j; k++)
            acc = clampv(acc - chol_mem[i*DIM_MAX + k] * chol_mem[j*DIM_MAX + k], -Q62, Q62);
          chol_mem[i*DIM_MAX + j] = sat32(div_round(acc, longint'(root)));
        end
      end
    end
    if (bad) begin
      points_q.push_back(mk_elem(0, 0, 0, 0, 0, 0, FAULT_NOT_PD, 1'b1));
      return;
    end
    gam = longint'(isqrt64(longint'(s) << 16));
    w0m = clampv(div_round(lam * 65536, s), W48_LO, W48_HI);
    w0c = clampv(w0m + 65536 - longint'((a2 + (64'h1 << 31)) >> 32) + longint'(beta_reg),
                 W48_LO, W48_HI);
    wi = clampv(div_round(longint'(1) << 32, 2 * s), W48_LO, W48_HI);
    for (c = 0; c <= n; c++) begin
      for (r = 0; r < n; r++) begin
        m = mean_mem[r];
        if (c == 0) begin
          points_q.push_back(mk_elem(0, r, m, m, w0m, w0c, FAULT_NONE, c == n && r == n-1));
        end else begin
          sh = 0;
          if (r >= c - 1) sh = rnd_shift(chol_mem[r*DIM_MAX + c - 1] * gam, 16);
          points_q.push_back(mk_elem(c, r, sat32(m + sh), sat32(m - sh), wi, wi, FAULT_NONE,
                                     c == n && r == n-1));
        end
      end
    end
  endtask

  function automatic int draw_wait();
    if (quiet) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_points(cur);
        items_sent++;
        gap_left <= draw_wait();
        if (gap_left == 0 && draw_wait() == 0 && pending_q.size() != 0) begin
          cur = pending_q.pop_front();
          func_d <= cur.func; row_d <= cur.row; col_d <= cur.col;
          value_d <= cur.value; done_d <= cur.done;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() != 0) begin
          cur = pending_q.pop_front();
          func_d <= cur.func; row_d <= cur.row; col_d <= cur.col;
          value_d <= cur.value; done_d <= cur.done;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      stall_next_cnt = stall_left;
      if (out_valid && !out_stall) begin
        if (points_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result col %0d row %0d", point_column,
                                     element_row);
        end else begin
          sigma_elem_t e;
          e = points_q.pop_front();
          if (e.col !== point_column || e.row !== element_row || e.plus !== plus_value ||
              e.minus !== minus_value || e.wm !== mean_weight || e.wc !== cov_weight ||
              e.fault !== fault_code || e.last !== last_result) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp col %0d row %0d plus %0d minus %0d wm %0d wc %0d f %0d l %0d",
                       e.col, e.row, e.plus, e.minus, e.wm, e.wc, e.fault, e.last);
              $display("         got col %0d row %0d plus %0d minus %0d wm %0d wc %0d f %0d l %0d",
                       point_column, element_row, plus_value, minus_value, mean_weight,
                       cov_weight, fault_code, last_result);
            end
          end
        end
        stall_next_cnt = draw_wait();
      end
      if (stall_next_cnt != 0) begin
        stall_nxt = 1'b1;
        stall_next_cnt--;
      end else begin
        stall_nxt = 1'b0;
      end
      out_stall <= stall_nxt;
      stall_left <= stall_next_cnt;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sigma_point_generator_unit failed");
      $finish;
    end
  end

  task automatic push_item(logic f, int r, int c, logic [31:0] v, logic d);
    load_item_t it;
    it.func = f; it.row = r[2:0]; it.col = c[2:0]; it.value = v; it.done = d;
    pending_q.push_back(it);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_DIM:   dim_reg = v[2:0];
      CFG_ALPHA: alpha_reg = v[25:0];
      CFG_BETA:  beta_reg = v[23:0];
      default:   kappa_reg = v;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || points_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // one load sequence for the current dimension; well-formed ones are diagonally dominant
  task automatic load_run(bit well_formed);
    int n, r, c;
    logic [31:0] v;
    n = (dim_reg == 0) ? 1 : int'(dim_reg);
    for (r = 0; r < n; r++) push_item(FUNC_MEAN, r, $urandom_range(0, 7), $urandom, 1'b0);
    for (r = 0; r < n; r++) begin
      for (c = 0; c <= r; c++) begin
        if ($urandom_range(0, 7) == 0)
          push_item($urandom_range(0, 1), 7, $urandom_range(0, 7), $urandom, 1'b0);
        if (!well_formed) v = $urandom;
        else if (r == c) v = $urandom_range(32'h0070_0000, 32'h1000_0000);
        else v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        push_item(FUNC_COV, r, c, v, r == n-1 && c == r);
      end
    end
  endtask

  task automatic random_config();
    cfg_write(CFG_DIM, $urandom_range(0, 7));
    cfg_write(CFG_ALPHA, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 32'h200_0000)
                                                     : $urandom_range(32'h40_0000, 32'h200_0000));
    cfg_write(CFG_BETA, $urandom_range(0, 24'hFF_FFFF));
    cfg_write(CFG_KAPPA, ($urandom_range(0, 4) == 0) ? $urandom
                                                     : $urandom_range(0, 32'h0008_0000) - 32'h0002_0000);
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    int runs;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // n taken as 1, extreme values, out-of-range and upper-triangle entries
    cfg_write(CFG_DIM, 0);
    push_item(FUNC_MEAN, 7, 0, 32'h1234_5678, 1'b0);
    push_item(FUNC_COV, 0, 7, 32'hFFFF_FFFF, 1'b0);
    push_item(FUNC_COV, 0, 3, 32'h8000_0000, 1'b0);
    push_item(FUNC_MEAN, 0, 0, 32'h7FFF_FFFF, 1'b0);
    push_item(FUNC_COV, 0, 0, 32'h7FFF_FFFF, 1'b1);
    wait_idle();
    // not positive definite
    push_item(FUNC_COV, 0, 0, 32'hFFFF_FFFF, 1'b1);
    wait_idle();
    push_item(FUNC_COV, 0, 0, 32'h0000_0000, 1'b1);
    wait_idle();
    // alpha minimum gives a non-positive spread, done on an out-of-range row
    cfg_write(CFG_ALPHA, 1);
    push_item(FUNC_MEAN, 7, 7, 32'h0, 1'b1);
    wait_idle();
    cfg_write(CFG_ALPHA, 32'h200_0000);
    cfg_write(CFG_BETA, 32'hFF_FFFF);
    cfg_write(CFG_KAPPA, 32'h7FFF_FFFF);
    cfg_write(CFG_DIM, 1);
    push_item(FUNC_MEAN, 0, 0, 32'h8000_0000, 1'b0);
    push_item(FUNC_COV, 0, 0, 32'h0001_0000, 1'b1);
    wait_idle();
    cfg_write(CFG_KAPPA, 32'h8000_0000);
    cfg_write(CFG_BETA, 0);
    push_item(FUNC_COV, 0, 0, 32'h0001_0000, 1'b1);
    wait_idle();
    cfg_write(CFG_KAPPA, 0);
    cfg_write(CFG_DIM, 7);
    load_run(1'b1);
    wait_idle();

    while (items_sent < ITEM_TARGET) begin
      random_config();
      for (runs = 0; runs < 3; runs++) load_run($urandom_range(0, 5) != 0);
      wait_idle();
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb_sigma_point_generator_unit passed");
    end else begin
      $display("tb_sigma_point_generator_unit failed");
    end
    $finish;
  end

endmodule
